// ----- hw/rtl/per_client_fixed_window_rate_limiter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Rate limiter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH
`define PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH

// same-cycle implication
`define PCFWRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCFWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pcfwrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Rate limiter package
// Table geometry, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package pcfwrl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SCAN_W        = IDX_W + 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] MAX_REQUESTS_RST   = 16'd100;
  localparam logic [15:0] WINDOW_SECONDS_RST = 16'd1;
  localparam logic [15:0] SWEEP_INTERVAL_RST = 16'd10;
  localparam logic [15:0] IDLE_AGE_RST       = 16'd60;
  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

  typedef enum logic [1:0] {
    CFG_MAX_REQUESTS   = 2'd0,
    CFG_WINDOW_SECONDS = 2'd1,
    CFG_SWEEP_INTERVAL = 2'd2,
    CFG_IDLE_AGE       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } eng_state_t;

  typedef struct packed {
    logic [15:0] max_requests;
    logic [15:0] window_seconds;
    logic [15:0] sweep_interval;
    logic [15:0] idle_age;
  } cfg_t;

  typedef struct packed {
    logic [31:0] client_address;
    logic [31:0] now_seconds;
    logic        sweep;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] window_start;
    logic [15:0] count;
  } entry_t;

  typedef struct packed {
    logic        allowed;
    logic        new_client;
    logic        table_full;
    logic [15:0] request_count;
  } res_t;

endpackage

// ----- hw/rtl/pcfwrl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcfwrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/pcfwrl_front.sv -----
// ----------------------------------------------------------------------------
// Rate limiter front end
// Accepts requests, decides the sweep per request, and queues them.
// ----------------------------------------------------------------------------
module pcfwrl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  pcfwrl_pkg::cfg_t   cfg,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_client_address,
  input  logic [31:0]        in_now_seconds,
  output logic               q_valid,
  output pcfwrl_pkg::req_t   q_item,
  input  logic               q_deq
);

  pcfwrl_pkg::req_t                 q_mem_r [pcfwrl_pkg::QUEUE_DEPTH];
  logic [pcfwrl_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pcfwrl_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pcfwrl_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [31:0]                      last_sweep_r, last_sweep_nxt;
  logic [31:0]                      since_sweep;
  logic                             push_ok;
  logic                             deq_ok;
  logic                             do_sweep;
  pcfwrl_pkg::req_t                 new_item;

  localparam logic [pcfwrl_pkg::QPTR_W-1:0] PTR_LAST =
    pcfwrl_pkg::QPTR_W'(pcfwrl_pkg::QUEUE_DEPTH - 1);
  localparam logic [pcfwrl_pkg::QCNT_W-1:0] CNT_FULL =
    pcfwrl_pkg::QCNT_W'(pcfwrl_pkg::QUEUE_DEPTH);

  assign in_full = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign deq_ok  = q_deq && q_valid;

  always_comb begin
    since_sweep             = in_now_seconds - last_sweep_r;
    do_sweep                = since_sweep > {16'd0, cfg.sweep_interval};
    new_item.client_address = in_client_address;
    new_item.now_seconds    = in_now_seconds;
    new_item.sweep          = do_sweep;
    last_sweep_nxt          = last_sweep_r;
    wr_ptr_nxt              = wr_ptr_r;
    rd_ptr_nxt              = rd_ptr_r;
    cnt_nxt                 = cnt_r;
    if (push_ok) begin
      if (do_sweep) begin
        last_sweep_nxt = in_now_seconds;
      end
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (deq_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, deq_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
      last_sweep_r <= '0;
    end else begin
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      cnt_r        <= cnt_nxt;
      last_sweep_r <= last_sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- hw/rtl/pcfwrl_engine.sv -----
// ----------------------------------------------------------------------------
// Rate limiter table engine
// Scans the client table per request (sweep, lookup, free slot search),
// then writes the client's entry, if it has or gets one, and loads the result register.
// ----------------------------------------------------------------------------
`include "per_client_fixed_window_rate_limiter_unit_macros.svh"

module pcfwrl_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  pcfwrl_pkg::cfg_t   cfg,
  input  logic               q_valid,
  input  pcfwrl_pkg::req_t   q_item,
  output logic               q_deq,
  output logic               res_vld,
  output pcfwrl_pkg::res_t   res,
  input  logic               res_pop
);

  localparam int IW = pcfwrl_pkg::IDX_W;
  localparam int SW = pcfwrl_pkg::SCAN_W;
  localparam logic [SW-1:0] SCAN_END = SW'(pcfwrl_pkg::TABLE_ENTRIES);
  localparam logic [IW-1:0] IDX_LAST = IW'(pcfwrl_pkg::TABLE_ENTRIES - 1);

  pcfwrl_pkg::eng_state_t state_r, state_nxt;
  logic [SW-1:0]          scan_cnt_r, scan_cnt_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]          chk_idx_r, chk_idx_nxt;
  pcfwrl_pkg::req_t       item_r, item_nxt;
  logic                   hit_found_r, hit_found_nxt;
  logic [IW-1:0]          hit_idx_r, hit_idx_nxt;
  logic [31:0]            hit_start_r, hit_start_nxt;
  logic [15:0]            hit_count_r, hit_count_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic [pcfwrl_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                   out_vld_r, out_vld_nxt;
  pcfwrl_pkg::res_t       out_r, out_nxt;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  pcfwrl_pkg::entry_t     ram_wdata;
  logic [IW-1:0]          ram_raddr;
  pcfwrl_pkg::entry_t     ram_rdata;

  logic                   pop_ok;
  logic                   ent_valid;
  logic                   ent_stale;
  logic                   ent_live;
  logic [31:0]            ent_age;
  logic [31:0]            hit_age;
  logic [16:0]            cnt_inc;
  logic [15:0]            cnt_sat;

  pcfwrl_ram #(
    .WIDTH ($bits(pcfwrl_pkg::entry_t)),
    .DEPTH (pcfwrl_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pop_ok    = res_pop && out_vld_r;
  assign ram_raddr = scan_cnt_r[IW-1:0];
  assign res_vld   = out_vld_r;
  assign res       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcfwrl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    item_nxt       = item_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_start_nxt  = hit_start_r;
    hit_count_nxt  = hit_count_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    out_vld_nxt    = out_vld_r && !pop_ok;
    out_nxt        = out_r;
    q_deq          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    ram_wdata.address      = item_r.client_address;
    ram_wdata.window_start = item_r.now_seconds;
    ram_wdata.count        = 16'd1;

    ent_valid = valid_r[chk_idx_r];
    ent_age   = item_r.now_seconds - ram_rdata.window_start;
    ent_stale = item_r.sweep && (ent_age > {16'd0, cfg.idle_age});
    ent_live  = ent_valid && !ent_stale;
    hit_age   = item_r.now_seconds - hit_start_r;
    cnt_inc   = {1'b0, hit_count_r} + 17'd1;
    cnt_sat   = cnt_inc[16] ? pcfwrl_pkg::COUNT_MAX : cnt_inc[15:0];

    unique case (state_r)
      pcfwrl_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_deq          = 1'b1;
          item_nxt       = q_item;
          scan_cnt_nxt   = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = pcfwrl_pkg::ST_SCAN;
        end
      end
      pcfwrl_pkg::ST_SCAN: begin
        if (scan_cnt_r < SCAN_END) begin
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_cnt_r[IW-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (chk_vld_r) begin
          if (ent_valid && ent_stale) begin
            valid_nxt[chk_idx_r] = 1'b0;
          end
          if (ent_live && !hit_found_r &&
              (ram_rdata.address == item_r.client_address)) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = chk_idx_r;
            hit_start_nxt = ram_rdata.window_start;
            hit_count_nxt = ram_rdata.count;
          end
          if (!ent_live && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (chk_idx_r == IDX_LAST) begin
            state_nxt = pcfwrl_pkg::ST_UPDATE;
          end
        end
      end
      pcfwrl_pkg::ST_UPDATE: begin
        if (!out_vld_r || pop_ok) begin
          out_vld_nxt           = 1'b1;
          out_nxt.allowed       = 1'b1;
          out_nxt.new_client    = 1'b0;
          out_nxt.table_full    = 1'b0;
          out_nxt.request_count = 16'd1;
          state_nxt             = pcfwrl_pkg::ST_IDLE;
          if (!hit_found_r) begin
            if (free_found_r) begin
              ram_we                = 1'b1;
              ram_waddr             = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              out_nxt.new_client    = 1'b1;
            end else begin
              out_nxt.table_full = 1'b1;
            end
          end else if (hit_age >= {16'd0, cfg.window_seconds}) begin
            ram_we = 1'b1;
          end else begin
            ram_we                 = 1'b1;
            ram_wdata.window_start = hit_start_r;
            ram_wdata.count        = cnt_sat;
            out_nxt.allowed        = cnt_inc <= {1'b0, cfg.max_requests};
            out_nxt.request_count  = cnt_sat;
          end
        end
      end
      default: begin
        state_nxt = pcfwrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      out_vld_r <= 1'b0;
      chk_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      out_vld_r <= out_vld_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r   <= scan_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    item_r       <= item_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_start_r  <= hit_start_nxt;
    hit_count_r  <= hit_count_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    out_r        <= out_nxt;
  end

  `PCFWRL_ASSERT_NEXT(a_update_loads_result,
    (state_r == pcfwrl_pkg::ST_UPDATE) && (!out_vld_r || pop_ok), out_vld_r,
    "finished update did not load the result register")
  `PCFWRL_ASSERT_NOW(a_alloc_needs_free,
    ram_we && !hit_found_r, free_found_r,
    "table write for a new client without a free entry")
  `PCFWRL_ASSERT_NOW(a_deq_only_idle,
    q_deq, (state_r == pcfwrl_pkg::ST_IDLE) && q_valid,
    "request taken from queue while engine busy")
  `PCFWRL_ASSERT_NOW(a_no_write_in_scan,
    state_r == pcfwrl_pkg::ST_SCAN, !ram_we,
    "table written during scan")

endmodule

// ----- hw/rtl/per_client_fixed_window_rate_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// Per-client fixed-window rate limiter
// Tracks request counts per client address in a 64-entry table and admits
// requests while a client's count stays within the window limit.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_push / in_full  in_client_address, in_now_seconds
//  out      out_empty / out_pop out_allowed, out_new_client, out_table_full,
//                              out_request_count
//  cfg      cfg_we             cfg_index, cfg_wdata
//
// The engine checks one table entry per cycle through the table RAM's single
// read port, scanning all TABLE_ENTRIES entries for every request.
// A two-entry request queue accepts requests during a scan until it is full.
// The engine stalls only in its final update step while a result waits.
// Reset clears the valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_client_fixed_window_rate_limiter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_client_address,
  input  logic [31:0] in_now_seconds,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_allowed,
  output logic        out_new_client,
  output logic        out_table_full,
  output logic [15:0] out_request_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  pcfwrl_pkg::cfg_t cfg_r, cfg_nxt;
  pcfwrl_pkg::req_t q_item;
  pcfwrl_pkg::res_t res;
  logic             q_valid;
  logic             q_deq;
  logic             res_vld;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (pcfwrl_pkg::cfg_idx_t'(cfg_index))
        pcfwrl_pkg::CFG_MAX_REQUESTS:   cfg_nxt.max_requests   = cfg_wdata;
        pcfwrl_pkg::CFG_WINDOW_SECONDS: cfg_nxt.window_seconds = cfg_wdata;
        pcfwrl_pkg::CFG_SWEEP_INTERVAL: cfg_nxt.sweep_interval = cfg_wdata;
        pcfwrl_pkg::CFG_IDLE_AGE:       cfg_nxt.idle_age       = cfg_wdata;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_requests   <= pcfwrl_pkg::MAX_REQUESTS_RST;
      cfg_r.window_seconds <= pcfwrl_pkg::WINDOW_SECONDS_RST;
      cfg_r.sweep_interval <= pcfwrl_pkg::SWEEP_INTERVAL_RST;
      cfg_r.idle_age       <= pcfwrl_pkg::IDLE_AGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcfwrl_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_client_address (in_client_address),
    .in_now_seconds    (in_now_seconds),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_deq             (q_deq)
  );

  pcfwrl_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_deq   (q_deq),
    .res_vld (res_vld),
    .res     (res),
    .res_pop (out_pop)
  );

  assign out_empty         = !res_vld;
  assign out_allowed       = res.allowed;
  assign out_new_client    = res.new_client;
  assign out_table_full    = res.table_full;
  assign out_request_count = res.request_count;

endmodule
